// ===== hw/rtl/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants, codes and handshake structs of the bicubic patch evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int GRID_POINTS_X_DEF  = 64;
    localparam int GRID_POINTS_Y_DEF  = 64;
    localparam int NUM_PROPERTIES_DEF = 5;

    // data path widths: Q32.16 values, cell differences, Q.32 normalized points
    localparam int DW  = 48;
    localparam int GDW = 49;
    localparam int QW  = 64;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 56;

    localparam logic [DW-1:0] DATA_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [DW-1:0] DATA_MIN = 48'h8000_0000_0000;
    localparam logic [DW-1:0] ONE_Q16  = 48'h0000_0001_0000;

    localparam logic [2:0] OP_VALUE    = 3'd0;
    localparam logic [2:0] OP_DDX      = 3'd1;
    localparam logic [2:0] OP_DDY      = 3'd2;
    localparam logic [2:0] OP_WR_XGRID = 3'd3;
    localparam logic [2:0] OP_WR_YGRID = 3'd4;
    localparam logic [2:0] OP_WR_COEF  = 3'd5;
    localparam logic [2:0] OP_WR_VALID = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_ZERO_W    = 3'd3;
    localparam logic [2:0] ST_SATURATED = 3'd4;

    localparam logic [2:0] AXIS_NONE = 3'd5;

    typedef struct packed {
        logic start;
        logic frac32;   // 32 fraction bits, else 16
    } t_div_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_rsp;

endpackage

// ===== hw/rtl/bpe_div.sv =====
// ----------------------------------------------------------------------------
// bpe_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^fb / den),
// clamped to a given maximum with a saturation flag.
// ----------------------------------------------------------------------------
module bpe_div import bpe_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_div_req       i_req,
    input  logic [GDW-1:0] i_num,
    input  logic [GDW-1:0] i_den,
    input  logic [QW-1:0]  i_max,
    output t_div_rsp       o_rsp,
    output logic [QW-1:0]  o_quot
);

    localparam int CW = $clog2(GDW + 32 + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state         r_state;
    logic [CW-1:0]  r_cnt;
    logic [GDW-1:0] r_num;
    logic [GDW-1:0] r_den;
    logic [GDW-1:0] r_rem;
    logic [QW-1:0]  r_q;
    logic [QW-1:0]  r_max;
    logic [QW-1:0]  r_quot;
    logic           r_ovf;
    logic           r_done;
    logic           r_sat;

    logic [GDW:0] rem_sh;
    logic [GDW:0] rem_sub;
    logic         ge;
    logic         over;

    assign rem_sh  = {r_rem, r_num[GDW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign over    = r_ovf || (r_q > r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_max   <= i_max;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= i_req.frac32 ? CW'(GDW + 32) : CW'(GDW + 16);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= ge ? rem_sub[GDW-1:0] : rem_sh[GDW-1:0];
                    r_q   <= {r_q[QW-2:0], ge};
                    // a bit shifted out of the top means the quotient is too big
                    r_ovf <= r_ovf | r_q[QW-1];
                    r_num <= {r_num[GDW-2:0], 1'b0};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_quot  <= over ? r_max : r_q;
                    r_sat   <= over;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp  = '{done: r_done, sat: r_sat};
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/bicubic_patch_evaluator.sv =====
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator
// Grid, coefficient and valid stores plus a sequenced evaluator of a bicubic
// patch or its x/y derivative at a point, in signed Q32.16.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser: operation; tdata (low bit up): property_req,
//           |           | cell_x, cell_y, coeff_index, point_x, point_y, write_data
//  m_axis   | out       | tdata (low bit up): result_value, status
//  cfg      | in        | i_cfg_we, i_cfg_idx (0 x axis, 1 y axis), i_cfg_data
//
//  Writes and rejected reads go from accept straight to the done state. An
//  evaluation runs two normalizing divisions on the shared bit-serial divider,
//  five Horner passes on one shared 32x32 multiplier, and one further division
//  for derivatives. After reset a clearing pass over GRID_POINTS_X*GRID_POINTS_Y
//  entries (4096 by default, rounded up to powers of two) zeroes the valid store;
//  s_axis_tready stays low meanwhile. One transaction at a time; a stalled result
//  holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator import bpe_pkg::*; #(
    parameter int GRID_POINTS_X  = GRID_POINTS_X_DEF,
    parameter int GRID_POINTS_Y  = GRID_POINTS_Y_DEF,
    parameter int NUM_PROPERTIES = NUM_PROPERTIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [2:0]           i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // property_req[2:0] cell_x[8:3] cell_y[14:9] coeff_index[18:15]
    // point_x[66:19] point_y[114:67] write_data[162:115], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_value[47:0] status[50:48], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int XW  = $clog2(GRID_POINTS_X);
    localparam int YW  = $clog2(GRID_POINTS_Y);
    localparam int PW  = (NUM_PROPERTIES > 1) ? $clog2(NUM_PROPERTIES) : 1;
    localparam int CAW = PW + XW + YW + 4;
    localparam int VAW = XW + YW;
    localparam int IW  = 11;
    localparam logic [IW-1:0] GX_L = IW'(GRID_POINTS_X);
    localparam logic [IW-1:0] GY_L = IW'(GRID_POINTS_Y);
    localparam logic [3:0]    NP_L = 4'(NUM_PROPERTIES);

    localparam logic CFG_X_AXIS = 1'b0;
    localparam logic CFG_Y_AXIS = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_VAL, S_G1, S_G2, S_CHK, S_DIVX, S_DIVXW, S_DIVY, S_DIVYW,
        S_HPRE, S_HLOAD, S_MAG, S_MUL, S_SCL, S_ADD, S_DDIV, S_DDIVW, S_DONE
    } t_state;

    function automatic logic ovf49(input logic [GDW-1:0] s);
        return s[GDW-1] != s[GDW-2];
    endfunction

    function automatic logic [DW-1:0] clamp49(input logic [GDW-1:0] s);
        logic [DW-1:0] v;
        if (s[GDW-1] != s[GDW-2]) begin
            v = s[GDW-1] ? DATA_MIN : DATA_MAX;
        end else begin
            v = s[DW-1:0];
        end
        return v;
    endfunction

    function automatic logic [GDW-1:0] abs49(input logic [GDW-1:0] s);
        return s[GDW-1] ? (GDW'(0) - s) : s;
    endfunction

    // ---------------- input unpack ----------------
    logic [2:0]    in_op;
    logic [2:0]    in_prop;
    logic [5:0]    in_cx;
    logic [5:0]    in_cy;
    logic [3:0]    in_k;
    logic [DW-1:0] in_px;
    logic [DW-1:0] in_py;
    logic [DW-1:0] in_wd;

    assign in_op   = s_axis_tuser;
    assign in_prop = s_axis_tdata[2:0];
    assign in_cx   = s_axis_tdata[8:3];
    assign in_cy   = s_axis_tdata[14:9];
    assign in_k    = s_axis_tdata[18:15];
    assign in_px   = s_axis_tdata[66:19];
    assign in_py   = s_axis_tdata[114:67];
    assign in_wd   = s_axis_tdata[162:115];

    // ---------------- registers ----------------
    t_state          r_state;
    logic [2:0]      r_xaxis;
    logic [2:0]      r_yaxis;
    logic [2:0]      r_op;
    logic [2:0]      r_prop;
    logic [5:0]      r_cx;
    logic [5:0]      r_cy;
    logic [DW-1:0]   r_px;
    logic [DW-1:0]   r_py;
    logic [DW-1:0]   r_x0;
    logic [DW-1:0]   r_y0;
    logic [GDW-1:0]  r_dx;
    logic [GDW-1:0]  r_dy;
    logic [GDW-1:0]  r_wx;
    logic [GDW-1:0]  r_wy;
    logic [QW-1:0]   r_xh;
    logic [QW-1:0]   r_yh;
    logic [DW-1:0]   r_acc;
    logic [DW-1:0]   r_b [4];
    logic [DW-1:0]   r_dbl;
    logic [DW-1:0]   r_amag;
    logic [QW-1:0]   r_tmag;
    logic            r_neg;
    logic [2:0]      r_pp;
    logic [63:0]     r_pmul;
    logic [111:0]    r_prod;
    logic [DW-1:0]   r_mres;
    logic [1:0]      r_l;
    logic [1:0]      r_j;
    logic            r_outer;
    logic            r_sat;
    logic [DW-1:0]   r_res;
    logic [2:0]      r_stat;
    logic            r_mvalid;
    logic [DW-1:0]   r_out_res;
    logic [2:0]      r_out_stat;
    logic [VAW-1:0]  r_clr;
    logic [DW-1:0]   r_xg_rd;
    logic [DW-1:0]   r_yg_rd;
    logic            r_vld_rd;
    logic [DW-1:0]   r_coef_rd;

    logic [DW-1:0] mem_xg   [2**XW];
    logic [DW-1:0] mem_yg   [2**YW];
    logic [DW-1:0] mem_coef [2**CAW];
    logic          mem_vld  [2**VAW];

    // ---------------- accept and write decode ----------------
    logic          acc_in;
    logic [IW-1:0] cx_e;
    logic [IW-1:0] cy_e;
    logic          cx_ok;
    logic          cy_ok;
    logic          prop_ok;
    logic          rd_bad;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign cx_e          = IW'(in_cx);
    assign cy_e          = IW'(in_cy);
    assign cx_ok         = cx_e < GX_L;
    assign cy_ok         = cy_e < GY_L;
    assign prop_ok       = {1'b0, in_prop} < NP_L;
    assign rd_bad        = !prop_ok || ((cx_e + IW'(1)) >= GX_L) || ((cy_e + IW'(1)) >= GY_L);

    logic           xg_we;
    logic           yg_we;
    logic           coef_we;
    logic           vld_we;
    logic [VAW-1:0] vld_waddr;
    logic           vld_wdata;
    logic [CAW-1:0] coef_waddr;

    assign xg_we      = acc_in && (in_op == OP_WR_XGRID) && cx_ok;
    assign yg_we      = acc_in && (in_op == OP_WR_YGRID) && cy_ok;
    assign coef_we    = acc_in && (in_op == OP_WR_COEF) && prop_ok && cx_ok && cy_ok;
    assign vld_we     = (r_state == S_CLEAR) ||
                        (acc_in && (in_op == OP_WR_VALID) && cx_ok && cy_ok);
    assign vld_waddr  = (r_state == S_CLEAR) ? r_clr : {XW'(in_cx), YW'(in_cy)};
    assign vld_wdata  = (r_state == S_CLEAR) ? 1'b0 : in_wd[0];
    assign coef_waddr = {PW'(in_prop), XW'(in_cx), YW'(in_cy), in_k};

    // ---------------- read addresses ----------------
    logic [XW-1:0]  xg_raddr;
    logic [YW-1:0]  yg_raddr;
    logic [VAW-1:0] vld_raddr;
    logic [3:0]     cidx;
    logic [CAW-1:0] coef_raddr;

    // first read the left grid point, then the right one
    assign xg_raddr   = (r_state == S_VAL) ? XW'(r_cx) : XW'(r_cx) + XW'(1);
    assign yg_raddr   = (r_state == S_VAL) ? YW'(r_cy) : YW'(r_cy) + YW'(1);
    assign vld_raddr  = {XW'(r_cx), YW'(r_cy)};
    assign cidx       = (r_op == OP_DDY) ? {r_l, r_j} : {r_j, r_l};
    assign coef_raddr = {PW'(r_prop), XW'(r_cx), YW'(r_cy), cidx};

    always_ff @(posedge i_clk) begin
        if (xg_we) begin
            mem_xg[XW'(in_cx)] <= in_wd;
        end
        r_xg_rd <= mem_xg[xg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (yg_we) begin
            mem_yg[YW'(in_cy)] <= in_wd;
        end
        r_yg_rd <= mem_yg[yg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            mem_coef[coef_waddr] <= in_wd;
        end
        r_coef_rd <= mem_coef[coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            mem_vld[vld_waddr] <= vld_wdata;
        end
        r_vld_rd <= mem_vld[vld_raddr];
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xaxis <= AXIS_NONE;
            r_yaxis <= AXIS_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_AXIS: r_xaxis <= i_cfg_data;
                CFG_Y_AXIS: r_yaxis <= i_cfg_data;
                default:    r_xaxis <= r_xaxis;
            endcase
        end
    end

    // ---------------- shared divider ----------------
    t_div_req       div_req;
    t_div_rsp       div_rsp;
    logic [GDW-1:0] div_num;
    logic [GDW-1:0] div_den;
    logic [QW-1:0]  div_max;
    logic [QW-1:0]  div_quot;
    logic           deriv;
    logic [GDW-1:0] dw_sel;
    logic           dneg;

    assign deriv  = (r_op != OP_VALUE);
    assign dw_sel = (r_op == OP_DDX) ? r_wx : r_wy;
    assign dneg   = r_acc[DW-1] != dw_sel[GDW-1];

    always_comb begin
        div_req.start  = (r_state == S_DIVX) || (r_state == S_DIVY) || (r_state == S_DDIV);
        div_req.frac32 = (r_state != S_DDIV);
        case (r_state)
            S_DIVX: begin
                div_num = abs49(r_dx);
                div_den = abs49(r_wx);
                div_max = {1'b0, {(QW-1){1'b1}}};
            end
            S_DIVY: begin
                div_num = abs49(r_dy);
                div_den = abs49(r_wy);
                div_max = {1'b0, {(QW-1){1'b1}}};
            end
            default: begin
                div_num = abs49({r_acc[DW-1], r_acc});
                div_den = abs49(dw_sel);
                div_max = QW'(DATA_MIN) - QW'(!dneg);
            end
        endcase
    end

    bpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_max   (div_max),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    logic [QW-1:0] norm_x;
    logic [QW-1:0] norm_y;
    logic [DW-1:0] dres;

    assign norm_x = (r_dx[GDW-1] != r_wx[GDW-1]) ? (QW'(0) - div_quot) : div_quot;
    assign norm_y = (r_dy[GDW-1] != r_wy[GDW-1]) ? (QW'(0) - div_quot) : div_quot;
    assign dres   = dneg ? (DW'(0) - div_quot[DW-1:0]) : div_quot[DW-1:0];

    // ---------------- Horner datapath ----------------
    logic          use_x;
    logic [QW-1:0] t_val;
    logic [1:0]    j_end;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [1:0]    pp_prev;
    logic [111:0]  pp_term;
    logic [79:0]   m_hi;
    logic          scl_over;
    logic [DW-1:0] scl_val;
    logic [DW-1:0] addend;
    logic [GDW-1:0] add_sum;
    logic [DW-1:0] add_val;
    logic [49:0]   tri_sum;
    logic          tri_ovf;
    logic [DW-1:0] tri_val;
    logic [GDW-1:0] dbl_sum;

    assign use_x   = (r_op == OP_DDY) != r_outer;
    assign t_val   = use_x ? r_xh : r_yh;
    assign j_end   = (r_outer && deriv) ? 2'd1 : 2'd0;

    assign mul_a   = r_pp[1] ? {16'b0, r_amag[DW-1:32]} : r_amag[31:0];
    assign mul_b   = r_pp[0] ? r_tmag[63:32] : r_tmag[31:0];
    assign mul_p   = mul_a * mul_b;
    assign pp_prev = r_pp[1:0] - 2'd1;

    always_comb begin
        case (pp_prev)
            2'd0:    pp_term = 112'(r_pmul);
            2'd3:    pp_term = 112'(r_pmul) << 64;
            default: pp_term = 112'(r_pmul) << 32;
        endcase
    end

    assign m_hi     = r_prod[111:32];
    assign scl_over = r_neg ? (m_hi > 80'(DATA_MIN)) : (m_hi > 80'(DATA_MAX));
    assign scl_val  = scl_over ? (r_neg ? DATA_MIN : DATA_MAX)
                    : (r_neg ? (DW'(0) - m_hi[DW-1:0]) : m_hi[DW-1:0]);

    assign addend  = !r_outer ? r_coef_rd : ((deriv && (r_j == 2'd2)) ? r_dbl : r_b[r_j]);
    assign add_sum = {r_mres[DW-1], r_mres} + {addend[DW-1], addend};
    assign add_val = clamp49(add_sum);

    // 3*c3 and 2*c2 for the derivative polynomial
    assign tri_sum = {{2{r_b[3][DW-1]}}, r_b[3]} + {r_b[3][DW-1], r_b[3], 1'b0};
    assign tri_ovf = !((tri_sum[49:47] == 3'b000) || (tri_sum[49:47] == 3'b111));
    assign tri_val = tri_ovf ? (tri_sum[49] ? DATA_MIN : DATA_MAX) : tri_sum[DW-1:0];
    assign dbl_sum = {r_b[2], 1'b0};

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + VAW'(1);
                    if (r_clr == {VAW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc_in) begin
                        r_op   <= in_op;
                        r_prop <= in_prop;
                        r_cx   <= in_cx;
                        r_cy   <= in_cy;
                        r_px   <= in_px;
                        r_py   <= in_py;
                        r_sat  <= 1'b0;
                        r_res  <= '0;
                        r_stat <= ST_OK;
                        r_state <= S_DONE;
                        case (in_op)
                            OP_VALUE, OP_DDX, OP_DDY: begin
                                if (rd_bad) begin
                                    r_stat <= ST_RANGE;
                                end else begin
                                    r_state <= S_VAL;
                                end
                            end
                            OP_WR_XGRID: r_stat <= cx_ok ? ST_OK : ST_RANGE;
                            OP_WR_YGRID: r_stat <= cy_ok ? ST_OK : ST_RANGE;
                            OP_WR_COEF:  r_stat <= (prop_ok && cx_ok && cy_ok) ? ST_OK : ST_RANGE;
                            OP_WR_VALID: r_stat <= (cx_ok && cy_ok) ? ST_OK : ST_RANGE;
                            default:     r_stat <= ST_RANGE;
                        endcase
                    end
                end
                S_VAL: begin
                    r_state <= S_G1;
                end
                S_G1: begin
                    if (!r_vld_rd) begin
                        r_stat  <= ST_INVALID;
                        r_state <= S_DONE;
                    end else begin
                        r_x0    <= r_xg_rd;
                        r_y0    <= r_yg_rd;
                        r_dx    <= {r_px[DW-1], r_px} - {r_xg_rd[DW-1], r_xg_rd};
                        r_dy    <= {r_py[DW-1], r_py} - {r_yg_rd[DW-1], r_yg_rd};
                        r_state <= S_G2;
                    end
                end
                S_G2: begin
                    r_wx    <= {r_xg_rd[DW-1], r_xg_rd} - {r_x0[DW-1], r_x0};
                    r_wy    <= {r_yg_rd[DW-1], r_yg_rd} - {r_y0[DW-1], r_y0};
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_DONE;
                    if ((r_wx == '0) || (r_wy == '0)) begin
                        r_stat <= ST_ZERO_W;
                    end else if ((r_op == OP_DDX) && (r_prop == r_xaxis)) begin
                        r_res <= ONE_Q16;
                    end else if ((r_op == OP_DDX) && (r_prop == r_yaxis)) begin
                        r_res <= '0;
                    end else if ((r_op == OP_DDY) && (r_prop == r_yaxis)) begin
                        r_res <= ONE_Q16;
                    end else if ((r_op == OP_DDY) && (r_prop == r_xaxis)) begin
                        r_res <= '0;
                    end else begin
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    r_state <= S_DIVXW;
                end
                S_DIVXW: begin
                    if (div_rsp.done) begin
                        r_xh    <= norm_x;
                        r_sat   <= r_sat | div_rsp.sat;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    r_state <= S_DIVYW;
                end
                S_DIVYW: begin
                    if (div_rsp.done) begin
                        r_yh    <= norm_y;
                        r_sat   <= r_sat | div_rsp.sat;
                        r_l     <= 2'd0;
                        r_j     <= 2'd3;
                        r_outer <= 1'b0;
                        r_state <= S_HPRE;
                    end
                end
                S_HPRE: begin
                    // wait for the leading coefficient to come out of memory
                    r_state <= S_HLOAD;
                end
                S_HLOAD: begin
                    if (!r_outer) begin
                        r_acc <= r_coef_rd;
                    end else if (!deriv) begin
                        r_acc <= r_b[3];
                    end else begin
                        r_acc <= tri_val;
                        r_dbl <= clamp49(dbl_sum);
                        r_sat <= r_sat | tri_ovf | ovf49(dbl_sum);
                    end
                    r_j     <= 2'd2;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_amag  <= r_acc[DW-1] ? (DW'(0) - r_acc) : r_acc;
                    r_tmag  <= t_val[QW-1] ? (QW'(0) - t_val) : t_val;
                    r_neg   <= r_acc[DW-1] != t_val[QW-1];
                    r_pp    <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // partial product k is formed at step k and summed at step k+1
                    if (r_pp != 3'd4) begin
                        r_pmul <= mul_p;
                    end
                    if (r_pp == 3'd1) begin
                        r_prod <= pp_term;
                    end else if (r_pp != 3'd0) begin
                        r_prod <= r_prod + pp_term;
                    end
                    r_pp <= r_pp + 3'd1;
                    if (r_pp == 3'd4) begin
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_mres  <= scl_val;
                    r_sat   <= r_sat | scl_over;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= add_val;
                    r_sat <= r_sat | ovf49(add_sum);
                    if (r_j != j_end) begin
                        r_j     <= r_j - 2'd1;
                        r_state <= S_MAG;
                    end else if (!r_outer) begin
                        r_b[r_l] <= add_val;
                        r_j      <= 2'd3;
                        r_state  <= S_HPRE;
                        if (r_l == 2'd3) begin
                            r_outer <= 1'b1;
                            r_l     <= 2'd0;
                        end else begin
                            r_l <= r_l + 2'd1;
                        end
                    end else if (!deriv) begin
                        r_res   <= add_val;
                        r_stat  <= (r_sat || ovf49(add_sum)) ? ST_SATURATED : ST_OK;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    r_state <= S_DDIVW;
                end
                S_DDIVW: begin
                    if (div_rsp.done) begin
                        r_res   <= dres;
                        r_stat  <= (r_sat || div_rsp.sat) ? ST_SATURATED : ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid   <= 1'b1;
                        r_out_res  <= r_res;
                        r_out_stat <= r_stat;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {{(M_TDATA_W - DW - 3){1'b0}}, r_out_stat, r_out_res};

`ifndef ASSERT_OFF
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_stat != ST_OK) && (r_out_stat != ST_SATURATED))
            |-> (r_out_res == '0))
        else $error("error result carries a nonzero value");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!m_axis_tvalid && !s_axis_tready))
        else $error("activity during valid store clearing");

    a_mul_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_pp <= 3'd4))
        else $error("multiply step counter overran");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ((r_state == S_DIVXW) || (r_state == S_DIVYW) ||
                          (r_state == S_DDIVW)))
        else $error("divider finished outside a wait state");
`endif

endmodule
